FILE: rtl/hsvrgb_pkg.sv
// Shared constants, stage payload types and sector codes for the HSV to RGB converter.
package hsvrgb_pkg;

   localparam int COLOR_BITS = 8;
   localparam int HUE_BITS   = 9;
   localparam int FRAC_BITS  = 6;
   localparam int SECTOR_BITS = 3;

   localparam int MAXC      = (1 << COLOR_BITS) - 1;
   localparam int FULL_TURN = 360;
   localparam int SIXTY     = 60;
   localparam int SCALE_Q   = SIXTY * MAXC;
   localparam int SCALE_Q4  = SCALE_Q / 4;
   localparam int SCALE_Q_BITS = COLOR_BITS + FRAC_BITS;

   // hue / 60 as (hue * 1093) >> 16, exact for hue below 360
   localparam int HUE_RECIP      = 1093;
   localparam int HUE_RECIP_BITS = 11;
   localparam int HUE_SHIFT      = 16;
   localparam int HUE_PROD_BITS  = HUE_BITS + HUE_RECIP_BITS;

   // numerator widths
   localparam int NUM_P_BITS = 2 * COLOR_BITS;
   localparam int NUM_Q_BITS = 2 * COLOR_BITS + FRAC_BITS;
   localparam int DIV_Q_BITS = NUM_Q_BITS - 2;

   // reciprocal constants, ceil(2^shift / divisor), exact over the numerator range
   localparam int SHIFT_P = NUM_P_BITS + $clog2(MAXC);
   localparam int SHIFT_Q = DIV_Q_BITS + $clog2(SCALE_Q4);
   localparam int KP_BITS = NUM_P_BITS + 1;
   localparam int KQ_BITS = DIV_Q_BITS + 1;
   localparam int PROD_P_BITS = NUM_P_BITS + KP_BITS;
   localparam int PROD_Q_BITS = DIV_Q_BITS + KQ_BITS;

   localparam logic [63:0] RECIP_P_WIDE =
      ((64'd1 << SHIFT_P) + 64'(MAXC) - 64'd1) / 64'(MAXC);
   localparam logic [63:0] RECIP_Q_WIDE =
      ((64'd1 << SHIFT_Q) + 64'(SCALE_Q4) - 64'd1) / 64'(SCALE_Q4);
   localparam logic [KP_BITS-1:0] RECIP_P = KP_BITS'(RECIP_P_WIDE);
   localparam logic [KQ_BITS-1:0] RECIP_Q = KQ_BITS'(RECIP_Q_WIDE);

   // hue sectors
   localparam logic [SECTOR_BITS-1:0] SECT_RED_YELLOW   = 3'd0;
   localparam logic [SECTOR_BITS-1:0] SECT_YELLOW_GREEN = 3'd1;
   localparam logic [SECTOR_BITS-1:0] SECT_GREEN_CYAN   = 3'd2;
   localparam logic [SECTOR_BITS-1:0] SECT_CYAN_BLUE    = 3'd3;
   localparam logic [SECTOR_BITS-1:0] SECT_BLUE_MAGENTA = 3'd4;

   typedef struct packed {
      logic                  valid;
      logic [HUE_BITS-1:0]   hue_deg;
      logic [COLOR_BITS-1:0] saturation;
      logic [COLOR_BITS-1:0] brightness;
   } pixel_type;

   typedef struct packed {
      logic                   valid;
      logic                   black;
      logic [SECTOR_BITS-1:0] sector;
      logic [FRAC_BITS-1:0]   frac;
      logic [COLOR_BITS-1:0]  saturation;
      logic [COLOR_BITS-1:0]  brightness;
   } sector_type;

   typedef struct packed {
      logic                   valid;
      logic                   black;
      logic [SECTOR_BITS-1:0] sector;
      logic [COLOR_BITS-1:0]  brightness;
      logic [NUM_P_BITS-1:0]  num_p;
      logic [NUM_Q_BITS-1:0]  num_q;
      logic [NUM_Q_BITS-1:0]  num_t;
   } product_type;

   typedef struct packed {
      logic                  valid;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } result_type;

endpackage

FILE: rtl/hsvrgb_if.sv
// Valid/ready channel interfaces for HSV pixels in and RGB pixels out.
interface hsvrgb_req_if import hsvrgb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [HUE_BITS-1:0]   hue_deg;
   logic [COLOR_BITS-1:0] saturation;
   logic [COLOR_BITS-1:0] brightness;

   modport source (output valid, output hue_deg, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue_deg, input saturation, input brightness,
                   output ready);
endinterface

interface hsvrgb_rsp_if import hsvrgb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COLOR_BITS-1:0] red;
   logic [COLOR_BITS-1:0] green;
   logic [COLOR_BITS-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/hsv_to_rgb_convert.sv
// Top level of the HSV to RGB converter: six-stage pipeline with a shared stall.
//
//   channel    direction  payload                          transaction when
//   req_chan   in         hue_deg, saturation, brightness  valid && ready
//   rsp_chan   out        red, green, blue                 valid && ready
//
// One pixel per cycle while rsp_chan does not hold a response; the depth is set
// by the two-stage hue decode, the two product stages and the reciprocal
// divide stage ahead of the output register.
// Reset clears every stage valid bit; payload registers are not reset.
// A response held by rsp_chan freezes all stages together, so nothing is
// dropped or repeated; req_chan.ready follows that same stall.
module hsv_to_rgb_convert import hsvrgb_pkg::*; (
   input logic          clock,
   input logic          reset,
   hsvrgb_req_if.sink   req_chan,
   hsvrgb_rsp_if.source rsp_chan
);

   logic        advance;
   pixel_type   pixel;
   sector_type  sect;
   product_type prod;
   result_type  result;

   assign advance = !result.valid || rsp_chan.ready;

   assign req_chan.ready   = advance;
   assign pixel.valid      = req_chan.valid;
   assign pixel.hue_deg    = req_chan.hue_deg;
   assign pixel.saturation = req_chan.saturation;
   assign pixel.brightness = req_chan.brightness;

   hsvrgb_sector u_sector (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pixel   (pixel),
      .sect    (sect)
   );

   hsvrgb_product u_product (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sect    (sect),
      .prod    (prod)
   );

   hsvrgb_divide u_divide (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .prod    (prod),
      .result  (result)
   );

   assign rsp_chan.valid = result.valid;
   assign rsp_chan.red   = result.red;
   assign rsp_chan.green = result.green;
   assign rsp_chan.blue  = result.blue;

endmodule

FILE: rtl/hsvrgb_sector.sv
// Hue decode stages: wrap and range check, sector by reciprocal, fraction within sector.
module hsvrgb_sector import hsvrgb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  pixel_type  pixel,
   output sector_type sect
);

   logic                     a_valid_ff;
   logic                     a_black_ff;
   logic [HUE_BITS-1:0]      a_hue_ff;
   logic [HUE_PROD_BITS-1:0] a_prod_ff;
   logic [COLOR_BITS-1:0]    a_sat_ff;
   logic [COLOR_BITS-1:0]    a_bri_ff;

   logic [HUE_BITS-1:0]      hue_in;
   logic                     black_in;
   logic [HUE_PROD_BITS-1:0] prod_in;
   logic [SECTOR_BITS-1:0]   sector_in;
   logic [HUE_BITS-1:0]      base_in;
   logic [HUE_BITS-1:0]      frac_in;
   sector_type               sect_ff;

   // hue of a full turn wraps to zero; beyond that the pixel is black
   always_comb begin
      black_in = (pixel.hue_deg > HUE_BITS'(FULL_TURN));
      hue_in   = pixel.hue_deg;
      if (pixel.hue_deg >= HUE_BITS'(FULL_TURN)) begin
         hue_in = '0;
      end
      prod_in = HUE_PROD_BITS'(hue_in) * HUE_PROD_BITS'(HUE_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= pixel.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_black_ff <= black_in;
         a_hue_ff   <= hue_in;
         a_prod_ff  <= prod_in;
         a_sat_ff   <= pixel.saturation;
         a_bri_ff   <= pixel.brightness;
      end
   end

   // fraction = hue - 60 * sector, with 60 * sector as 64 * sector - 4 * sector
   always_comb begin
      sector_in = a_prod_ff[HUE_SHIFT +: SECTOR_BITS];
      base_in   = (HUE_BITS'(sector_in) << 6) - (HUE_BITS'(sector_in) << 2);
      frac_in   = a_hue_ff - base_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sect_ff.valid <= 1'b0;
      end else if (advance) begin
         sect_ff.valid <= a_valid_ff;
      end
      if (advance) begin
         sect_ff.black      <= a_black_ff;
         sect_ff.sector     <= sector_in;
         sect_ff.frac       <= frac_in[FRAC_BITS-1:0];
         sect_ff.saturation <= a_sat_ff;
         sect_ff.brightness <= a_bri_ff;
      end
   end

   assign sect = sect_ff;

endmodule

FILE: rtl/hsvrgb_product.sv
// Numerator stages: saturation scaled by fraction and by sixty minus fraction, then the three brightness products.
module hsvrgb_product import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  sector_type  sect,
   output product_type prod
);

   logic                    c_valid_ff;
   logic                    c_black_ff;
   logic [SECTOR_BITS-1:0]  c_sector_ff;
   logic [COLOR_BITS-1:0]   c_bri_ff;
   logic [COLOR_BITS-1:0]   c_pm_ff;
   logic [SCALE_Q_BITS-1:0] c_sf_ff;
   logic [SCALE_Q_BITS-1:0] c_sg_ff;

   logic [FRAC_BITS-1:0]    rest_in;
   logic [SCALE_Q_BITS-1:0] sf_in;
   logic [SCALE_Q_BITS-1:0] sg_in;
   logic [COLOR_BITS-1:0]   pm_in;
   logic [SCALE_Q_BITS-1:0] diff_q_in;
   logic [SCALE_Q_BITS-1:0] diff_t_in;
   product_type             prod_ff;

   always_comb begin
      rest_in = FRAC_BITS'(SIXTY) - sect.frac;
      sf_in   = SCALE_Q_BITS'(sect.saturation) * SCALE_Q_BITS'(sect.frac);
      sg_in   = SCALE_Q_BITS'(sect.saturation) * SCALE_Q_BITS'(rest_in);
      pm_in   = COLOR_BITS'(MAXC) - sect.saturation;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= sect.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_black_ff  <= sect.black;
         c_sector_ff <= sect.sector;
         c_bri_ff    <= sect.brightness;
         c_pm_ff     <= pm_in;
         c_sf_ff     <= sf_in;
         c_sg_ff     <= sg_in;
      end
   end

   always_comb begin
      diff_q_in = SCALE_Q_BITS'(SCALE_Q) - c_sf_ff;
      diff_t_in = SCALE_Q_BITS'(SCALE_Q) - c_sg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else if (advance) begin
         prod_ff.valid <= c_valid_ff;
      end
      if (advance) begin
         prod_ff.black      <= c_black_ff;
         prod_ff.sector     <= c_sector_ff;
         prod_ff.brightness <= c_bri_ff;
         prod_ff.num_p      <= NUM_P_BITS'(c_bri_ff) * NUM_P_BITS'(c_pm_ff);
         prod_ff.num_q      <= NUM_Q_BITS'(c_bri_ff) * NUM_Q_BITS'(diff_q_in);
         prod_ff.num_t      <= NUM_Q_BITS'(c_bri_ff) * NUM_Q_BITS'(diff_t_in);
      end
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/hsvrgb_divide.sv
// Constant division by reciprocal multiply, then sector routing and black forcing into the output register.
module hsvrgb_divide import hsvrgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  product_type prod,
   output result_type  result
);

   logic                   e_valid_ff;
   logic                   e_black_ff;
   logic [SECTOR_BITS-1:0] e_sector_ff;
   logic [COLOR_BITS-1:0]  e_bri_ff;
   logic [PROD_P_BITS-1:0] e_prod_p_ff;
   logic [PROD_Q_BITS-1:0] e_prod_q_ff;
   logic [PROD_Q_BITS-1:0] e_prod_t_ff;

   logic [COLOR_BITS-1:0]  p_in;
   logic [COLOR_BITS-1:0]  q_in;
   logic [COLOR_BITS-1:0]  t_in;
   logic [COLOR_BITS-1:0]  red_in;
   logic [COLOR_BITS-1:0]  green_in;
   logic [COLOR_BITS-1:0]  blue_in;
   result_type             result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         e_valid_ff <= prod.valid;
      end
   end

   // the Q and T divisor is 60 * MAXC: drop a factor of four by shift first
   always_ff @(posedge clock) begin
      if (advance) begin
         e_black_ff  <= prod.black;
         e_sector_ff <= prod.sector;
         e_bri_ff    <= prod.brightness;
         e_prod_p_ff <= PROD_P_BITS'(prod.num_p) * PROD_P_BITS'(RECIP_P);
         e_prod_q_ff <= PROD_Q_BITS'(prod.num_q[NUM_Q_BITS-1:2]) * PROD_Q_BITS'(RECIP_Q);
         e_prod_t_ff <= PROD_Q_BITS'(prod.num_t[NUM_Q_BITS-1:2]) * PROD_Q_BITS'(RECIP_Q);
      end
   end

   always_comb begin
      p_in = e_prod_p_ff[SHIFT_P +: COLOR_BITS];
      q_in = e_prod_q_ff[SHIFT_Q +: COLOR_BITS];
      t_in = e_prod_t_ff[SHIFT_Q +: COLOR_BITS];
      case (e_sector_ff)
         SECT_RED_YELLOW: begin
            red_in = e_bri_ff; green_in = t_in;     blue_in = p_in;
         end
         SECT_YELLOW_GREEN: begin
            red_in = q_in;     green_in = e_bri_ff; blue_in = p_in;
         end
         SECT_GREEN_CYAN: begin
            red_in = p_in;     green_in = e_bri_ff; blue_in = t_in;
         end
         SECT_CYAN_BLUE: begin
            red_in = p_in;     green_in = q_in;     blue_in = e_bri_ff;
         end
         SECT_BLUE_MAGENTA: begin
            red_in = t_in;     green_in = p_in;     blue_in = e_bri_ff;
         end
         default: begin
            red_in = e_bri_ff; green_in = p_in;     blue_in = q_in;
         end
      endcase
      if (e_black_ff) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff.valid <= 1'b0;
      end else if (advance) begin
         result_ff.valid <= e_valid_ff;
      end
      if (advance) begin
         result_ff.red   <= red_in;
         result_ff.green <= green_in;
         result_ff.blue  <= blue_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: dv/hsvrgb_pixel_checker.sv
// Checker for the HSV to RGB converter: predicts each pixel and compares the responses.
module hsvrgb_pixel_checker import hsvrgb_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   hsvrgb_req_if req_mon,
   hsvrgb_rsp_if rsp_mon,
   output int    mismatches,
   output int    outstanding
);

   typedef struct packed {
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] green;
      logic [COLOR_BITS-1:0] blue;
   } rgb_pixel_type;

   rgb_pixel_type rgb_expected_q[$];

   function automatic rgb_pixel_type hsv_to_rgb_pixel(input logic [HUE_BITS-1:0]   hue,
                                                      input logic [COLOR_BITS-1:0] sat,
                                                      input logic [COLOR_BITS-1:0] val);
      longint unsigned        h, s, v, f;
      logic [SECTOR_BITS-1:0] sect;
      logic [COLOR_BITS-1:0]  lvl_p, lvl_q, lvl_t;
      rgb_pixel_type          px;
      h  = hue;
      s  = sat;
      v  = val;
      px = '0;
      if (h == FULL_TURN) h = 0;
      if (h < FULL_TURN) begin
         sect  = SECTOR_BITS'(h / SIXTY);
         f     = h % SIXTY;
         lvl_p = COLOR_BITS'(v * (MAXC - s) / MAXC);
         lvl_q = COLOR_BITS'(v * (SCALE_Q - s * f) / SCALE_Q);
         lvl_t = COLOR_BITS'(v * (SCALE_Q - s * (SIXTY - f)) / SCALE_Q);
         case (sect)
            SECT_RED_YELLOW:   px = '{val, lvl_t, lvl_p};
            SECT_YELLOW_GREEN: px = '{lvl_q, val, lvl_p};
            SECT_GREEN_CYAN:   px = '{lvl_p, val, lvl_t};
            SECT_CYAN_BLUE:    px = '{lvl_p, lvl_q, val};
            SECT_BLUE_MAGENTA: px = '{lvl_t, lvl_p, val};
            default:           px = '{val, lvl_p, lvl_q};
         endcase
      end
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : monitor
      rgb_pixel_type want;
      if (reset) begin
         rgb_expected_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rgb_expected_q.size() == 0) begin
               report_mismatch($sformatf("response %0d/%0d/%0d with none outstanding",
                                         rsp_mon.red, rsp_mon.green, rsp_mon.blue));
            end else begin
               want = rgb_expected_q.pop_front();
               if (rsp_mon.red !== want.red)
                  report_mismatch($sformatf("red got %0d want %0d", rsp_mon.red, want.red));
               if (rsp_mon.green !== want.green)
                  report_mismatch($sformatf("green got %0d want %0d",
                                            rsp_mon.green, want.green));
               if (rsp_mon.blue !== want.blue)
                  report_mismatch($sformatf("blue got %0d want %0d", rsp_mon.blue, want.blue));
            end
         end
         if (req_mon.valid && req_mon.ready)
            rgb_expected_q.push_back(hsv_to_rgb_pixel(req_mon.hue_deg, req_mon.saturation,
                                                      req_mon.brightness));
      end
      outstanding = rgb_expected_q.size();
   end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the HSV to RGB converter: clock, reset, pixel stimulus and verdict.
module tb_top;
   import hsvrgb_pkg::*;

   localparam int HUE_TOP = (1 << HUE_BITS) - 1;
   localparam int BOUNDARY_HUES [15] =
      '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360, 361, HUE_TOP};

   logic clock;
   logic reset;
   int   mismatches;
   int   outstanding;
   bit   tx_quiet;

   hsvrgb_req_if req_chan();
   hsvrgb_rsp_if rsp_chan();

   hsv_to_rgb_convert u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hsvrgb_pixel_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 14));
   endfunction

   function automatic logic [COLOR_BITS-1:0] rand_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return COLOR_BITS'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [HUE_BITS-1:0]   hue,
                             input logic [COLOR_BITS-1:0] sat,
                             input logic [COLOR_BITS-1:0] val);
      int gap;
      if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.hue_deg    <= hue;
      req_chan.saturation <= sat;
      req_chan.brightness <= val;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // response side back-pressure
   initial begin
      int hold;
      bit rx_quiet;
      rsp_chan.ready = 1'b0;
      hold           = 0;
      rx_quiet       = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
            hold = draw_gap(rx_quiet);
            rsp_chan.ready <= (hold == 0);
         end else if (hold > 0) begin
            hold--;
            rsp_chan.ready <= (hold == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [HUE_BITS-1:0] hue;
      int                  pick;
      reset               = 1'b1;
      tx_quiet            = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.hue_deg    = '0;
      req_chan.saturation = '0;
      req_chan.brightness = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // sector boundaries, the wrap at a full turn and the black range
      for (int i = 0; i < 15; i++)
         send_pixel(HUE_BITS'(BOUNDARY_HUES[i]), '1, '1);
      send_pixel(9'd0, '0, '1);
      send_pixel(9'd200, '1, '0);
      send_pixel(9'd90, '0, '0);
      send_pixel(9'd30, 8'd128, 8'd200);
      send_pixel(9'd150, 8'h55, 8'haa);
      send_pixel(9'd330, 8'haa, 8'h55);

      for (int n = 0; n < 1750; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 3)
            hue = HUE_BITS'($urandom_range(FULL_TURN + 1, HUE_TOP));
         else if (pick == 3)
            hue = HUE_BITS'(SIXTY * $urandom_range(0, 6));
         else
            hue = HUE_BITS'($urandom_range(0, FULL_TURN - 1));
         send_pixel(hue, rand_level(), rand_level());
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
